// File: rtl/lcdcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdcf_pkg: shared types and constants for the segment LCD frame composer
// Command codes, panel format codes, segment table and the queue entry type.
// ----------------------------------------------------------------------------
package lcdcf_pkg;

	// command codes on the input stream
	localparam logic [3:0] FN_BIG        = 4'd0;
	localparam logic [3:0] FN_SMALL      = 4'd1;
	localparam logic [3:0] FN_DIGIT      = 4'd2;
	localparam logic [3:0] FN_UNIT       = 4'd3;
	localparam logic [3:0] FN_BLE        = 4'd4;
	localparam logic [3:0] FN_BATTERY    = 4'd5;
	localparam logic [3:0] FN_SMILEY     = 4'd6;
	localparam logic [3:0] FN_UPDATE     = 4'd7;
	localparam logic [3:0] FN_UPDATE_PAD = 4'd8;

	// panel formats
	localparam logic [1:0] PV_I2C  = 2'd0;
	localparam logic [1:0] PV_UART = 2'd1;
	localparam logic [1:0] PV_REV  = 2'd2;

	// symbol codes
	localparam logic signed [11:0] CODE_ONE = 12'sd1;
	localparam logic signed [11:0] CODE_TWO = 12'sd2;

	// segment bits and frame bytes
	localparam logic [7:0] SEG_MASK      = 8'hF7;
	localparam logic [7:0] SEG_UNIT_C    = 8'hA0;
	localparam logic [7:0] SEG_UNIT_F    = 8'h60;
	localparam logic [7:0] SEG_UNIT_KEEP = 8'h1F;
	localparam logic [7:0] SEG_HAPPY     = 8'h05;
	localparam logic [7:0] SEG_SAD       = 8'h06;
	localparam logic [7:0] SEG_FACE_KEEP = 8'hF8;
	localparam logic [7:0] SEG_BLE       = 8'h10;
	localparam logic [7:0] SEG_BLE_KEEP  = 8'hEF;
	localparam logic [7:0] SEG_POINT     = 8'h08;
	localparam logic [7:0] SEG_PT_KEEP   = 8'hF7;
	localparam logic [7:0] SEG_MINUS     = 8'h02;
	localparam logic [7:0] SEG_THOUSAND  = 8'h08;

	localparam logic [7:0] FB_I2C_MODE   = 8'h80;
	localparam logic [7:0] FB_I2C_START  = 8'h40;
	localparam logic [7:0] FB_I2C_CTRL   = 8'hC0;
	localparam logic [7:0] FB_ZERO       = 8'h00;
	localparam logic [7:0] FB_UART_SOF   = 8'hAA;
	localparam logic [7:0] FB_UART_EOF   = 8'h55;
	localparam logic [7:0] FB_REV_HEAD   = 8'h04;
	localparam logic [7:0] FB_REV_TAIL   = 8'hC8;

	// frame lengths in bytes
	localparam logic [4:0] LEN_I2C     = 5'd14;
	localparam logic [4:0] LEN_I2C_PAD = 5'd18;
	localparam logic [4:0] LEN_UART    = 5'd13;
	localparam logic [4:0] LEN_REV     = 5'd12;

	localparam int QUEUE_DEPTH_DEF = 2;

	// one decoded command: a masked buffer update or a frame request
	typedef struct packed {
		logic            is_frame;
		logic            padded;
		logic [5:0][7:0] keep;
		logic [5:0][7:0] set;
	} entry_t;

	typedef enum logic {
		BK_IDLE,
		BK_EMIT
	} back_state_t;

	function automatic logic [7:0] digit_seg(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0:    s = 8'hF5;
			4'd1:    s = 8'h05;
			4'd2:    s = 8'hD3;
			4'd3:    s = 8'h97;
			4'd4:    s = 8'h27;
			4'd5:    s = 8'hB6;
			4'd6:    s = 8'hF6;
			4'd7:    s = 8'h15;
			4'd8:    s = 8'hF7;
			4'd9:    s = 8'hB7;
			default: s = 8'h00;
		endcase
		return s & SEG_MASK;
	endfunction

endpackage
`default_nettype wire

// File: rtl/lcdcf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdcf_front: command intake and decode
// Registers a command with its digit estimates, then turns it into a
// masked buffer update or a frame request for the queue.
// ----------------------------------------------------------------------------
module lcdcf_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  [3:0]        in_func,
	input  wire  [11:0]       in_value,
	input  wire  [2:0]        in_position,
	input  wire               in_flag,
	output logic              push,
	output lcdcf_pkg::entry_t push_entry,
	input  wire               q_full
);
	import lcdcf_pkg::*;

	logic               s1_valid_q;
	logic [3:0]         func_s1;
	logic signed [11:0] value_s1;
	logic [2:0]         pos_s1;
	logic               flag_s1;
	logic [11:0]        mag_s1;
	logic [4:0]         q100_s1;
	logic [7:0]         t10_s1;

	logic [11:0] mag;
	logic [24:0] p100;
	logic [24:0] p10;
	logic [15:0] p205;
	logic [4:0]  t100;
	logic [7:0]  tens_w;
	logic [11:0] ones_w;
	logic [4:0]  hund_w;
	logic [3:0]  tens_d;
	logic [3:0]  ones_d;
	logic [3:0]  hund_d;
	logic        needs_push;
	logic        s1_done;
	entry_t      ent;

	// magnitude and reciprocal estimates of n/100 and n/10
	assign mag  = in_value[11] ? 12'(-in_value) : in_value;
	assign p100 = 25'(mag) * 25'd5243;
	assign p10  = 25'(mag) * 25'd6554;

	assign s1_done  = s1_valid_q && (!needs_push || !q_full);
	assign in_ready = !s1_valid_q || s1_done;
	assign push     = s1_valid_q && needs_push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1  <= in_func;
			value_s1 <= in_value;
			pos_s1   <= in_position;
			flag_s1  <= in_flag;
			mag_s1   <= mag;
			q100_s1  <= p100[23:19];
			t10_s1   <= p10[23:16];
		end
	end

	// digits from the registered estimates
	assign p205   = 16'(t10_s1) * 16'd205;
	assign t100   = p205[15:11];
	assign tens_w = t10_s1 - (8'({t100, 3'b000}) + 8'({t100, 1'b0}));
	assign ones_w = mag_s1 - (12'({t10_s1, 3'b000}) + 12'({t10_s1, 1'b0}));
	assign hund_w = (q100_s1 >= 5'd10) ? (q100_s1 - 5'd10) : q100_s1;
	assign tens_d = tens_w[3:0];
	assign ones_d = ones_w[3:0];
	assign hund_d = hund_w[3:0];

	always_comb begin
		needs_push   = 1'b0;
		ent.is_frame = 1'b0;
		ent.padded   = 1'b0;
		ent.keep     = {6{8'hFF}};
		ent.set      = '0;
		case (func_s1)
			FN_BIG: begin
				if (value_s1 <= 12'sd1999 && value_s1 >= -12'sd99) begin
					needs_push  = 1'b1;
					ent.keep[5] = 8'h00;
					ent.keep[4] = 8'h00;
					ent.keep[3] = 8'h00;
					if (value_s1 < 12'sd0) begin
						ent.set[5] = SEG_MINUS;
					end else if (value_s1 > 12'sd999) begin
						ent.set[5] = SEG_THOUSAND;
					end
					if (mag_s1 > 12'd99) begin
						ent.set[5] = ent.set[5] | digit_seg(hund_d);
					end
					ent.set[4] = (flag_s1 ? SEG_POINT : 8'h00) | digit_seg(tens_d);
					ent.set[3] = digit_seg(ones_d);
				end
			end
			FN_SMALL: begin
				if (value_s1 >= 12'sd0 && value_s1 <= 12'sd99) begin
					needs_push  = 1'b1;
					ent.keep[0] = 8'h00;
					ent.set[0]  = (flag_s1 ? SEG_POINT : 8'h00) | digit_seg(ones_d);
					ent.keep[1] = SEG_POINT;
					if (mag_s1 > 12'd9) begin
						ent.set[1] = digit_seg(tens_d);
					end
				end
			end
			FN_DIGIT: begin
				if (pos_s1 <= 3'd5 && pos_s1 != 3'd2 &&
				    value_s1 >= 12'sd0 && value_s1 <= 12'sd9) begin
					needs_push       = 1'b1;
					ent.keep[pos_s1] = 8'h00;
					ent.set[pos_s1]  = digit_seg(ones_d);
				end
			end
			FN_UNIT: begin
				needs_push  = 1'b1;
				ent.keep[2] = SEG_UNIT_KEEP;
				if (value_s1 == CODE_ONE) begin
					ent.set[2] = SEG_UNIT_C;
				end else if (value_s1 == CODE_TWO) begin
					ent.set[2] = SEG_UNIT_F;
				end
			end
			FN_BLE: begin
				needs_push  = 1'b1;
				ent.keep[2] = SEG_BLE_KEEP;
				ent.set[2]  = flag_s1 ? SEG_BLE : 8'h00;
			end
			FN_BATTERY: begin
				needs_push  = 1'b1;
				ent.keep[1] = SEG_PT_KEEP;
				ent.set[1]  = flag_s1 ? SEG_POINT : 8'h00;
			end
			FN_SMILEY: begin
				needs_push  = 1'b1;
				ent.keep[2] = SEG_FACE_KEEP;
				if (value_s1 == CODE_ONE) begin
					ent.set[2] = SEG_HAPPY;
				end else if (value_s1 == CODE_TWO) begin
					ent.set[2] = SEG_SAD;
				end
			end
			FN_UPDATE: begin
				needs_push   = 1'b1;
				ent.is_frame = 1'b1;
			end
			FN_UPDATE_PAD: begin
				needs_push   = 1'b1;
				ent.is_frame = 1'b1;
				ent.padded   = 1'b1;
			end
			default: begin
				needs_push = 1'b0;
			end
		endcase
	end

	assign push_entry = ent;

endmodule
`default_nettype wire

// File: rtl/lcdcf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdcf_queue: short command queue between decode and execution
// Register-based FIFO of decoded entries; depth must be a power of two, two or more, which the block does not enforce.
// ----------------------------------------------------------------------------
module lcdcf_queue #(
	parameter int DEPTH = lcdcf_pkg::QUEUE_DEPTH_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  lcdcf_pkg::entry_t push_entry,
	output logic              full,
	input  wire               pop,
	output logic              valid,
	output lcdcf_pkg::entry_t head
);
	import lcdcf_pkg::*;

	localparam int AW = $clog2(DEPTH);

	entry_t          mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;

	assign full  = (count_q == (AW+1)'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

// File: rtl/lcdcf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcdcf_back: segment buffer and frame emitter
// Applies buffer updates from the queue, drops frame requests under an unknown
// format, and streams frames byte by byte through an output register.
// ----------------------------------------------------------------------------
module lcdcf_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire  [1:0]        variant,
	input  wire               q_valid,
	input  lcdcf_pkg::entry_t q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [7:0]        out_byte,
	output logic              out_last
);
	import lcdcf_pkg::*;

	back_state_t     state_q;
	back_state_t     state_d;
	logic [4:0]      idx_q;
	logic [5:0][7:0] seg_buf_q;
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            out_last_q;

	logic            known_variant;
	logic [4:0]      frame_len;
	logic            is_last;
	logic            load;
	logic            buf_wr;
	logic            start;
	logic [7:0]      byte_d;
	logic [7:0]      xor_b;

	function automatic logic [7:0] rev8(input logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = b[7-i];
		end
		return r;
	endfunction

	assign known_variant = (variant == PV_I2C) || (variant == PV_UART) || (variant == PV_REV);
	assign xor_b = seg_buf_q[0] ^ seg_buf_q[1] ^ seg_buf_q[2] ^
	               seg_buf_q[3] ^ seg_buf_q[4] ^ seg_buf_q[5];

	always_comb begin
		case (variant)
			PV_I2C:  frame_len = q_head.padded ? LEN_I2C_PAD : LEN_I2C;
			PV_UART: frame_len = LEN_UART;
			PV_REV:  frame_len = LEN_REV;
			default: frame_len = 5'd0;
		endcase
	end

	assign is_last = (idx_q == frame_len - 5'd1);

	// byte at the current frame position
	always_comb begin
		byte_d = FB_ZERO;
		case (variant)
			PV_I2C: begin
				case (idx_q)
					5'd0:    byte_d = FB_I2C_MODE;
					5'd1:    byte_d = FB_I2C_START;
					5'd3:    byte_d = seg_buf_q[0];
					5'd5:    byte_d = seg_buf_q[1];
					5'd7:    byte_d = seg_buf_q[2];
					5'd9:    byte_d = seg_buf_q[3];
					5'd11:   byte_d = seg_buf_q[4];
					5'd13:   byte_d = seg_buf_q[5];
					5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14, 5'd16:
					         byte_d = FB_I2C_CTRL;
					default: byte_d = FB_ZERO;
				endcase
			end
			PV_UART: begin
				case (idx_q)
					5'd4:    byte_d = FB_UART_SOF;
					5'd5:    byte_d = seg_buf_q[5];
					5'd6:    byte_d = seg_buf_q[4];
					5'd7:    byte_d = seg_buf_q[3];
					5'd8:    byte_d = seg_buf_q[2];
					5'd9:    byte_d = seg_buf_q[1];
					5'd10:   byte_d = seg_buf_q[0];
					5'd11:   byte_d = xor_b;
					5'd12:   byte_d = FB_UART_EOF;
					default: byte_d = FB_ZERO;
				endcase
			end
			PV_REV: begin
				case (idx_q)
					5'd0:    byte_d = FB_REV_HEAD;
					5'd1:    byte_d = rev8(seg_buf_q[0]);
					5'd2:    byte_d = rev8(seg_buf_q[1]);
					5'd5:    byte_d = rev8(seg_buf_q[2]);
					5'd6:    byte_d = rev8(seg_buf_q[3]);
					5'd9:    byte_d = rev8(seg_buf_q[4]);
					5'd10:   byte_d = rev8(seg_buf_q[5]);
					5'd11:   byte_d = FB_REV_TAIL;
					default: byte_d = FB_ZERO;
				endcase
			end
			default: byte_d = FB_ZERO;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && q_head.is_frame && known_variant) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (load && is_last) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		load   = 1'b0;
		buf_wr = 1'b0;
		start  = 1'b0;
		q_pop  = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					if (!q_head.is_frame) begin
						buf_wr = 1'b1;
						q_pop  = 1'b1;
					end else if (!known_variant) begin
						q_pop = 1'b1;
					end else begin
						start = 1'b1;
					end
				end
			end
			BK_EMIT: begin
				load  = !out_valid_q || out_ready;
				q_pop = load && is_last;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			idx_q       <= '0;
			seg_buf_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start) begin
				idx_q <= '0;
			end else if (load) begin
				idx_q <= idx_q + 5'd1;
			end
			if (buf_wr) begin
				for (int i = 0; i < 6; i++) begin
					seg_buf_q[i] <= (seg_buf_q[i] & q_head.keep[i]) | q_head.set[i];
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= byte_d;
			out_last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	a_emit_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EMIT) |-> (q_valid && q_head.is_frame && idx_q < frame_len))
		else $error("emit position beyond frame length");
	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(load && is_last) |=> (state_q == BK_IDLE))
		else $error("frame did not end after last byte");
	a_buf_stable_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EMIT) |=> $stable(seg_buf_q))
		else $error("segment buffer changed during a frame");
`endif

endmodule
`default_nettype wire

// File: rtl/segment_lcd_composer_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_lcd_composer_framer: seven-segment thermometer LCD frame composer
// Keeps a six-byte segment buffer and emits it as a panel controller frame.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one command per beat. tuser carries the command code,
//   tdata carries value, position and flag. Number, digit and symbol
//   commands edit the segment buffer and produce no output beats; out of
//   range values are dropped. An update command streams the buffer on the
//   master side, one byte per beat, with tlast on the final byte.
//   Frames are 14 or 18 bytes (I2C pairs), 13 (UART with XOR check) or
//   12 (bit-reversed); with format code 3 an update emits nothing.
//   Flow: a command is registered in the intake register, then waits
//   in a short queue; the executor applies buffer edits at the queue head, and
//   an update there moves it to the emit state, which loads the output register.
//   Throughput: one frame byte per cycle while the receiver takes them; an
//   update occupies the executor until its last byte is loaded, set by its
//   byte counter; intake keeps decoding and queueing meanwhile.
//   Stall: a low m_axis_tready holds the output register and the byte
//   counter; once the queue fills, s_axis_tready drops.
//   Reset: buffer cleared, panel format 0, queue empty, no beat pending.
//   cfg_wdata is written when cfg_wen is high; write it only while idle.
// ----------------------------------------------------------------------------
module segment_lcd_composer_framer #(
	parameter int QUEUE_DEPTH = lcdcf_pkg::QUEUE_DEPTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [15:0] s_axis_tdata,   // value[11:0], position[14:12], flag[15]
	input  wire [3:0]  s_axis_tuser,   // func[3:0]
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [7:0] m_axis_tdata,   // frame_byte[7:0]
	output logic       m_axis_tlast,
	input  wire        cfg_wen,
	input  wire [1:0]  cfg_wdata
);
	import lcdcf_pkg::*;

	logic [1:0] panel_variant_q;
	logic       push;
	entry_t     push_entry;
	logic       q_full;
	logic       q_pop;
	logic       q_valid;
	entry_t     q_head;

	// panel format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_variant_q <= PV_I2C;
		end else if (cfg_wen) begin
			panel_variant_q <= cfg_wdata;
		end
	end

	// intake and decode
	lcdcf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_func     (s_axis_tuser),
		.in_value    (s_axis_tdata[11:0]),
		.in_position (s_axis_tdata[14:12]),
		.in_flag     (s_axis_tdata[15]),
		.push        (push),
		.push_entry  (push_entry),
		.q_full      (q_full)
	);

	// hold decoded commands until the executor is free
	lcdcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.valid      (q_valid),
		.head       (q_head)
	);

	// buffer edits and frame streaming
	lcdcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.variant   (panel_variant_q),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the segment LCD frame composer
// Drives buffer and update commands on the slave stream and tracks the segment
// buffer in its own shadow copy. Every update yields a list of frame bytes,
// which are matched in order against the master stream. Directed rows come
// first, then random phases under every panel format. Both sides idle at
// random, and one stretch holds the receiver off until the input stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import lcdcf_pkg::*;

	// codes the package leaves unnamed
	localparam logic [3:0] FN_UNUSED = 4'd15;
	localparam logic [1:0] PV_NONE   = 2'd3;

	localparam int SETTLE_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int RX_HOLD_CYCLES  = 300;
	localparam int PRESSURE_ITEMS  = 12;
	localparam int PHASE_ITEMS     = 50;

	// seven-segment patterns for 0..9, index 0 in the low byte
	localparam logic [9:0][7:0] DIGIT_SEGS = {
		8'hB7, 8'hF7, 8'h15, 8'hF6, 8'hB6, 8'h27, 8'h97, 8'hD3, 8'h05, 8'hF5
	};

	// frames known by inspection, first byte in the top bits
	localparam logic [143:0] LIT_BLANK     = {112'h8040C000C000C000C000C000C000, 32'h0};
	localparam logic [143:0] LIT_BLANK_PAD = 144'h8040C000C000C000C000C000C000C000C000;
	// big 1999 with point, small 99 with percent, on an empty buffer
	localparam logic [143:0] LIT_FULL      = {112'h8040C0BFC0B7C000C0B7C0BFC0BF, 32'h0};

	typedef struct packed {
		logic [3:0]         func;
		logic signed [11:0] value;
		logic [2:0]         pos;
		logic               flag;
		logic [4:0]         lit_len;  // 0: take the frame from the shadow model
		logic [143:0]       lit;
	} cmd_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} lcd_beat_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // value[11:0], position[14:12], flag[15]
	logic [3:0]  s_axis_tuser;   // func[3:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // frame_byte[7:0]
	logic        m_axis_tlast;
	logic        cfg_wen;
	logic [1:0]  cfg_wdata;

	// shadow of the block's state
	logic [7:0]  seg_buf [6];
	logic [1:0]  panel_fmt;

	lcd_beat_t   due_bytes [$];
	cmd_row_t    dir_tab [$];
	int          fail_count = 0;
	int          tx_calm = 0;
	int          rx_calm = 0;
	bit          burst_mode = 1'b0;
	bit          rx_hold_req = 1'b0;
	int          quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	segment_lcd_composer_framer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata)
	);

	function automatic logic [7:0] seg_code(int d);
		return DIGIT_SEGS[d % 10] & SEG_MASK;
	endfunction

	function automatic logic [7:0] bit_flip(logic [7:0] b);
		logic [7:0] r;
		for (int i = 0; i < 8; i++)
			r[i] = b[7 - i];
		return r;
	endfunction

	// queue the frame bytes an update produces under the current format
	function automatic void build_frame(bit padded);
		logic [7:0] fb [$];
		logic [7:0] chk;
		case (panel_fmt)
			PV_I2C: begin
				fb.push_back(FB_I2C_MODE);
				fb.push_back(FB_I2C_START);
				for (int i = 0; i < 6; i++) begin
					fb.push_back(FB_I2C_CTRL);
					fb.push_back(seg_buf[i]);
				end
				if (padded)
					repeat (2) begin
						fb.push_back(FB_I2C_CTRL);
						fb.push_back(FB_ZERO);
					end
			end
			PV_UART: begin
				chk = '0;
				repeat (4) fb.push_back(FB_ZERO);
				fb.push_back(FB_UART_SOF);
				for (int i = 5; i >= 0; i--) begin
					fb.push_back(seg_buf[i]);
					chk ^= seg_buf[i];
				end
				fb.push_back(chk);
				fb.push_back(FB_UART_EOF);
			end
			PV_REV: begin
				fb.push_back(FB_REV_HEAD);
				for (int i = 0; i < 6; i += 2) begin
					if (i != 0)
						repeat (2) fb.push_back(FB_ZERO);
					fb.push_back(bit_flip(seg_buf[i]));
					fb.push_back(bit_flip(seg_buf[i + 1]));
				end
				fb.push_back(FB_REV_TAIL);
			end
			default: ;  // unused format: nothing goes out
		endcase
		foreach (fb[i])
			due_bytes.push_back('{data: fb[i], last: (i == fb.size() - 1)});
	endfunction

	// advance the shadow buffer by one accepted command
	function automatic void apply_command(logic [3:0] func, logic signed [11:0] value,
			logic [2:0] pos, logic flag);
		int v;
		int mag;
		v = int'(value);
		mag = (v < 0) ? -v : v;
		case (func)
			FN_BIG: begin
				if (v <= 1999 && v >= -99) begin
					seg_buf[5] = (v > 999) ? SEG_THOUSAND : 8'h00;
					if (v < 0)
						seg_buf[5] = SEG_MINUS;
					seg_buf[4] = flag ? SEG_POINT : 8'h00;
					if (mag > 99)
						seg_buf[5] |= seg_code(mag / 100);
					// single digits still show a tens zero
					seg_buf[4] |= (mag > 9) ? seg_code(mag / 10) : seg_code(0);
					seg_buf[3] = seg_code(mag);
				end
			end
			FN_SMALL: begin
				if (v >= 0 && v <= 99) begin
					seg_buf[0] = flag ? SEG_POINT : 8'h00;
					seg_buf[1] &= SEG_POINT;  // keep the battery mark
					if (v > 9)
						seg_buf[1] |= seg_code(v / 10);
					seg_buf[0] |= seg_code(v);
				end
			end
			FN_DIGIT: begin
				if (pos <= 3'd5 && pos != 3'd2 && v >= 0 && v <= 9)
					seg_buf[pos] = seg_code(v);
			end
			FN_UNIT: begin
				seg_buf[2] &= SEG_UNIT_KEEP;
				if (value == CODE_ONE)
					seg_buf[2] |= SEG_UNIT_C;
				else if (value == CODE_TWO)
					seg_buf[2] |= SEG_UNIT_F;
			end
			FN_BLE: begin
				if (flag)
					seg_buf[2] |= SEG_BLE;
				else
					seg_buf[2] &= SEG_BLE_KEEP;
			end
			FN_BATTERY: begin
				if (flag)
					seg_buf[1] |= SEG_POINT;
				else
					seg_buf[1] &= SEG_PT_KEEP;
			end
			FN_SMILEY: begin
				seg_buf[2] &= SEG_FACE_KEEP;
				if (value == CODE_ONE)
					seg_buf[2] |= SEG_HAPPY;
				else if (value == CODE_TWO)
					seg_buf[2] |= SEG_SAD;
			end
			FN_UPDATE:     build_frame(1'b0);
			FN_UPDATE_PAD: build_frame(1'b1);
			default: ;
		endcase
	endfunction

	function automatic cmd_row_t row(logic [3:0] f, int v, int p, bit fl,
			int len = 0, logic [143:0] lit = '0);
		cmd_row_t r;
		r.func    = f;
		r.value   = v[11:0];
		r.pos     = p[2:0];
		r.flag    = fl;
		r.lit_len = len[4:0];
		r.lit     = lit;
		return r;
	endfunction

	// mostly well-formed commands, a fifth pure noise over the full fields
	function automatic cmd_row_t rand_cmd();
		cmd_row_t c;
		int pick;
		int p;
		c = row(FN_UPDATE, int'($urandom_range(0, 4095)), int'($urandom_range(0, 7)),
			bit'($urandom_range(0, 1)));
		pick = $urandom_range(0, 99);
		if (pick < 20)
			c.func = 4'($urandom_range(0, 15));
		else if (pick < 50)
			c.func = ($urandom_range(0, 2) == 0) ? FN_UPDATE_PAD : FN_UPDATE;
		else if (pick < 65) begin
			c.func  = FN_BIG;
			c.value = 12'(int'($urandom_range(0, 2098)) - 99);
		end else if (pick < 73) begin
			c.func  = FN_SMALL;
			c.value = 12'($urandom_range(0, 99));
		end else if (pick < 81) begin
			p = $urandom_range(0, 4);
			c.func  = FN_DIGIT;
			c.value = 12'($urandom_range(0, 9));
			c.pos   = 3'((p >= 2) ? p + 1 : p);
		end else if (pick < 86) begin
			c.func  = FN_UNIT;
			c.value = 12'($urandom_range(0, 3));
		end else if (pick < 90)
			c.func = FN_BLE;
		else if (pick < 94)
			c.func = FN_BATTERY;
		else begin
			c.func  = FN_SMILEY;
			c.value = 12'($urandom_range(0, 3));
		end
		return c;
	endfunction

	// idle count per beat, with runs of back-to-back beats
	function automatic int pick_wait(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 11) == 0) begin
			calm = $urandom_range(8, 25);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	// offer one command, wait for its beat, then update the shadow model
	task automatic send_cmd(input cmd_row_t c);
		int gap;
		int n0;
		gap = burst_mode ? 0 : pick_wait(tx_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= c.func;
		s_axis_tdata  <= {c.flag, c.pos, c.value};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		n0 = due_bytes.size();
		apply_command(c.func, c.value, c.pos, c.flag);
		if (c.lit_len != 0) begin
			// swap in the hand-written frame
			while (due_bytes.size() > n0) void'(due_bytes.pop_back());
			for (int i = 0; i < c.lit_len; i++)
				due_bytes.push_back('{data: c.lit[143 - 8 * i -: 8], last: (i == c.lit_len - 1)});
		end
	endtask

	// drop valid, wait out every frame byte, then let the executor settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (due_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_panel(input logic [1:0] fmt);
		cfg_wen   <= 1'b1;
		cfg_wdata <= fmt;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		panel_fmt = fmt;
	endtask

	// receiver: random stalls, one long hold on request, check every beat
	initial begin : rx_side
		int stall;
		lcd_beat_t want;
		m_axis_tready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = pick_wait(rx_calm);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall = RX_HOLD_CYCLES;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			if (due_bytes.size() == 0) begin
				$error("unexpected beat: frame_byte %h last %b", m_axis_tdata, m_axis_tlast);
				fail_count++;
			end else begin
				want = due_bytes.pop_front();
				if (m_axis_tdata !== want.data) begin
					$error("frame_byte: expected %h, got %h", want.data, m_axis_tdata);
					fail_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last: expected %b, got %b", want.last, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	// end the run when no beat moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : stimulus
		logic [1:0] phase_fmt [6];
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = FN_BIG;
		cfg_wen       = 1'b0;
		cfg_wdata     = PV_I2C;
		arst_n        = 1'b0;
		panel_fmt     = PV_I2C;
		foreach (seg_buf[i])
			seg_buf[i] = 8'h00;
		phase_fmt = '{PV_UART, PV_REV, PV_NONE, PV_I2C, PV_REV, PV_UART};

		// directed rows, all under the reset format
		dir_tab.push_back(row(FN_UPDATE, 0, 0, 0, 14, LIT_BLANK));
		dir_tab.push_back(row(FN_UPDATE_PAD, 0, 0, 0, 18, LIT_BLANK_PAD));
		dir_tab.push_back(row(FN_BIG, 1999, 0, 1));
		dir_tab.push_back(row(FN_SMALL, 99, 0, 1));
		dir_tab.push_back(row(FN_UPDATE, 0, 0, 0, 14, LIT_FULL));
		// out of range numbers and digits leave the buffer alone
		dir_tab.push_back(row(FN_BIG, 2000, 0, 0));
		dir_tab.push_back(row(FN_BIG, -100, 0, 1));
		dir_tab.push_back(row(FN_BIG, 2047, 7, 1));
		dir_tab.push_back(row(FN_BIG, -2048, 0, 0));
		dir_tab.push_back(row(FN_SMALL, -1, 0, 1));
		dir_tab.push_back(row(FN_SMALL, 100, 0, 0));
		dir_tab.push_back(row(FN_DIGIT, 3, 2, 0));
		dir_tab.push_back(row(FN_DIGIT, 4, 7, 0));
		dir_tab.push_back(row(FN_DIGIT, 10, 1, 0));
		dir_tab.push_back(row(FN_UPDATE, 0, 0, 0, 14, LIT_FULL));
		dir_tab.push_back(row(FN_BIG, -99, 0, 0));
		dir_tab.push_back(row(FN_SMALL, 5, 0, 0));
		dir_tab.push_back(row(FN_BATTERY, 0, 0, 1));
		dir_tab.push_back(row(FN_DIGIT, 7, 0, 0));
		dir_tab.push_back(row(FN_UNIT, 1, 0, 0));
		dir_tab.push_back(row(FN_SMILEY, 2, 0, 0));
		dir_tab.push_back(row(FN_BLE, 0, 0, 1));
		dir_tab.push_back(row(FN_BIG, 5, 0, 1));  // tens zero on a single digit
		dir_tab.push_back(row(FN_UNUSED, 0, 0, 1));
		dir_tab.push_back(row(FN_UPDATE, 0, 0, 0));
		dir_tab.push_back(row(FN_UNIT, 3, 0, 0));  // unknown code clears the unit
		dir_tab.push_back(row(FN_SMILEY, 0, 0, 0));
		dir_tab.push_back(row(FN_UPDATE_PAD, 0, 0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_cmd(dir_tab[i]);
		drain();

		foreach (phase_fmt[k]) begin
			set_panel(phase_fmt[k]);
			repeat (PHASE_ITEMS) send_cmd(rand_cmd());
			if (phase_fmt[k] == PV_I2C) begin
				// hold the receiver off and stream updates until intake stalls
				rx_hold_req = 1'b1;
				burst_mode  = 1'b1;
				repeat (PRESSURE_ITEMS) send_cmd(row(FN_UPDATE_PAD, 0, 0, 0));
				burst_mode  = 1'b0;
			end
			drain();
		end

		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
